/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the base64 decoder core.
// Depends on nothing; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge, ignored while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same, but also checked while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/b64d_pkg.sv */
// Package for the base64 decoder core: channel payloads, the result
// group type, status codes and the alphabet lookup. Depends on nothing.
`timescale 1ns / 1ps

package b64d_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_PAD  = 2'd2;
  localparam logic [1:0] ST_BAD_LEN  = 2'd3;

  localparam logic [7:0] PAD_CHAR   = 8'h3d;
  localparam logic [1:0] PHASE_LAST = 2'd3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;
  } b64d_out_t;

  // Up to three results produced by one input character.
  typedef struct packed {
    logic [23:0] data;    // decoded bytes, first byte in [23:16]
    logic [1:0]  count;   // number of results, 1 to 3
    logic        last;    // last flag goes on the final result
    logic [1:0]  status;
  } b64d_group_t;

  typedef struct packed {
    logic        push;
    b64d_group_t group;
  } b64d_push_t;

  // Returns {invalid, sextet}; invalid is set for anything outside the
  // alphabet, including the pad character.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h41 && c <= 8'h5a) begin
      t = c - 8'h41;
      return {1'b0, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      t = c - 8'h61 + 8'd26;
      return {1'b0, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      return {1'b0, t[5:0]};
    end else if (c == 8'h2b) begin
      return {1'b0, 6'd62};
    end else if (c == 8'h2f) begin
      return {1'b0, 6'd63};
    end
    return {1'b1, 6'd0};
  endfunction

endpackage

/* rtl/core/b64d_decode.sv */
// Character decoder: quad state, error checks and result group build.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_decode import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  b64d_in_t   in_data,
  output b64d_push_t push_out,
  output logic       dropping
);

  logic [1:0]  quad_phase, quad_phase_next;
  logic [17:0] sextet_accum, sextet_accum_next;
  logic [1:0]  pad_seen, pad_seen_next;
  logic        failed_drop, failed_drop_next;

  logic [6:0]  lookup;
  logic        is_pad;
  logic [5:0]  sextet;
  logic        err;
  logic [1:0]  err_code;
  logic [1:0]  pads;

  assign lookup = sextet_of(in_data.in_char);
  assign is_pad = (in_data.in_char == PAD_CHAR);
  assign sextet = is_pad ? 6'd0 : lookup[5:0];
  assign pads   = pad_seen + {1'b0, is_pad};

  always_comb begin
    quad_phase_next   = quad_phase;
    sextet_accum_next = sextet_accum;
    pad_seen_next     = pad_seen;
    failed_drop_next  = failed_drop;
    push_out          = '0;
    err               = 1'b0;
    err_code          = ST_OK;
    if (accept) begin
      if (failed_drop) begin
        // Drop everything up to the message end.
        if (in_data.in_last) begin
          failed_drop_next  = 1'b0;
          quad_phase_next   = 2'd0;
          sextet_accum_next = '0;
          pad_seen_next     = 2'd0;
        end
      end else begin
        if (!is_pad && lookup[6]) begin
          err      = 1'b1;
          err_code = ST_BAD_CHAR;
        end else if (is_pad && quad_phase < 2'd2) begin
          err      = 1'b1;
          err_code = ST_BAD_PAD;
        end else if (!is_pad && pad_seen != 2'd0) begin
          err      = 1'b1;
          err_code = ST_BAD_PAD;
        end else if (quad_phase != PHASE_LAST) begin
          if (in_data.in_last) begin
            err      = 1'b1;
            err_code = ST_BAD_LEN;
          end else begin
            pad_seen_next     = pad_seen + {1'b0, is_pad};
            sextet_accum_next = {sextet_accum[11:0], sextet};
            quad_phase_next   = quad_phase + 2'd1;
          end
        end else if (pads != 2'd0 && !in_data.in_last) begin
          // Padding is only legal in the final quad.
          err      = 1'b1;
          err_code = ST_BAD_PAD;
        end else begin
          push_out.push         = 1'b1;
          push_out.group.data   = {sextet_accum, sextet};
          push_out.group.count  = 2'd3 - pads;
          push_out.group.last   = in_data.in_last;
          push_out.group.status = ST_OK;
          quad_phase_next       = 2'd0;
          sextet_accum_next     = '0;
          pad_seen_next         = 2'd0;
        end

        if (err) begin
          push_out.push         = 1'b1;
          push_out.group.data   = '0;
          push_out.group.count  = 2'd1;
          push_out.group.last   = 1'b1;
          push_out.group.status = err_code;
          quad_phase_next       = 2'd0;
          sextet_accum_next     = '0;
          pad_seen_next         = 2'd0;
          failed_drop_next      = !in_data.in_last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_phase   <= 2'd0;
      sextet_accum <= '0;
      pad_seen     <= 2'd0;
      failed_drop  <= 1'b0;
    end else begin
      quad_phase   <= quad_phase_next;
      sextet_accum <= sextet_accum_next;
      pad_seen     <= pad_seen_next;
      failed_drop  <= failed_drop_next;
    end
  end

  assign dropping = failed_drop;

endmodule

/* rtl/core/b64d_group_fifo.sv */
// Two-entry queue of result groups between decoder and serializer.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_group_fifo import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  b64d_push_t  push_in,
  input  logic        pop,
  output logic        ready,
  output logic        head_valid,
  output b64d_group_t head
);

  logic        tail_valid;
  b64d_group_t tail;

  assign ready = !tail_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (push_in.push && pop) begin
      // Tail is empty whenever a push is allowed.
      head <= push_in.group;
    end else if (push_in.push) begin
      if (!head_valid) begin
        head       <= push_in.group;
        head_valid <= 1'b1;
      end else begin
        tail       <= push_in.group;
        tail_valid <= 1'b1;
      end
    end else if (pop) begin
      head       <= tail;
      head_valid <= tail_valid;
      tail_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/b64d_serializer.sv */
// Splits result groups into single results behind an output register.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_serializer import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  b64d_group_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output b64d_out_t   out_data
);

  logic [1:0] idx;
  logic       load;
  logic       final_one;
  logic [7:0] sel_byte;

  assign load      = head_valid && (!out_valid || out_ready);
  assign final_one = (idx == head.count - 2'd1);
  assign pop       = load && final_one;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.data[23:16];
      2'd1:    sel_byte = head.data[15:8];
      default: sel_byte = head.data[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= final_one ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte <= sel_byte;
      out_data.out_last <= head.last && final_one;
      out_data.status   <= head.status;
    end
  end

endmodule

/* rtl/core/base64_stream_decoder_core.sv */
// Top level of the streaming base64 decoder (standard alphabet, '=' pad).
// Depends on b64d_pkg, b64d_decode, b64d_group_fifo, b64d_serializer and
// assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one base64
//   character per transaction, with in_last on the final character of a
//   message. Output channel (out_valid/out_ready/out_data) carries one
//   decoded byte or one error status per transaction.
//   Every fourth character of a quad yields three, two or one bytes;
//   out_last marks the message's final byte and every error result.
//   After an error, drop the remaining characters up to in_last.
// Timing:
//   One character is taken every cycle while in_ready is high. The first
//   result of a quad goes through the group queue and the output register,
//   and its bytes then leave one per cycle while out_ready is high.
//   The group queue holds two result groups, so with a ready receiver
//   input stalls only when an error result lands behind a draining group.
// Reset (rst, synchronous): clear quad state, drop mode, the group queue and the output register.
// A stalled receiver holds the output register; input keeps flowing
// until the group queue fills, then in_ready falls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module base64_stream_decoder_core import b64d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  b64d_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output b64d_out_t out_data
);

  logic        accept;
  b64d_push_t  push;
  logic        dropping;
  logic        fifo_ready;
  logic        head_valid;
  b64d_group_t head;
  logic        pop;

  // Accept whenever the group queue has a free slot.
  assign in_ready = fifo_ready;
  assign accept   = in_valid && in_ready;

  b64d_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_data  (in_data),
    .push_out (push),
    .dropping (dropping)
  );

  b64d_group_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_in    (push),
    .pop        (pop),
    .ready      (fifo_ready),
    .head_valid (head_valid),
    .head       (head)
  );

  b64d_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Error results carry a zero byte and close the message.
  `ASSERT_CLK(a_err_result, out_valid && out_data.status != ST_OK |-> out_data.out_last && out_data.out_byte == 8'h00, "error result without last flag or with data")
  // While dropping, an accepted character never produces a group.
  `ASSERT_CLK(a_drop_silent, dropping && accept |-> !push.push, "result produced while dropping")
  // Output register goes empty when drained with nothing queued.
  `ASSERT_CLK(a_out_source, !head_valid && (!out_valid || out_ready) |=> !out_valid, "output valid without a queued group")
  // A group never pops from an empty queue.
  `ASSERT_ALWAYS(a_pop_head, pop |-> head_valid, "pop from empty group queue")

endmodule

/* test/tb_base64_stream_decoder_core.sv */
// Self-checking testbench for base64_stream_decoder_core: directed and random
// character streams go in, and each decoded byte or status is checked in order.
// Depends on b64d_pkg and the RTL of the decoder core.
`timescale 1ns / 1ps

module tb_base64_stream_decoder_core;
  import b64d_pkg::*;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  b64d_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  b64d_out_t out_data;

  // Idle percentages for the two sides; changed between test phases.
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 82;

  int error_count = 0;
  int live_chars  = 0;   // characters that were decoded, not dropped

  // Decoder state as the testbench tracks it.
  logic [1:0]  quad_pos   = 2'd0;
  logic [17:0] sextet_acc = 18'd0;
  logic [1:0]  pad_count  = 2'd0;
  logic        dropping   = 1'b0;

  // Decoded bytes and error statuses still owed by the block, oldest first.
  b64d_out_t decoded_queue[$];

  base64_stream_decoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hang guard: well past the slowest correct run.
  initial begin
    #2000000;
    $display("tb_base64_stream_decoder_core: errors");
    $finish;
  end

  // Map a character to its 6-bit value; bit 6 set means not in the alphabet.
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h40;
    if (c >= "A" && c <= "Z") v = c - "A";
    else if (c >= "a" && c <= "z") v = c - "a" + 8'd26;
    else if (c >= "0" && c <= "9") v = c - "0" + 8'd52;
    else if (c == "+") v = 8'd62;
    else if (c == "/") v = 8'd63;
    return v[6:0];
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'("A") + 8'(v);
    if (v < 6'd52) return 8'("a") + 8'(v - 6'd26);
    if (v < 6'd62) return 8'("0") + 8'(v - 6'd52);
    if (v == 6'd62) return 8'("+");
    return 8'("/");
  endfunction

  task automatic clear_quad();
    quad_pos   = 2'd0;
    sextet_acc = 18'd0;
    pad_count  = 2'd0;
  endtask

  // Queue one error status and enter drop mode unless the message ends here.
  task automatic flag_error(input logic [1:0] code, input logic last);
    decoded_queue.push_back({8'h00, 1'b1, code});
    clear_quad();
    dropping = ~last;
  endtask

  // Advance the decoder state by one accepted character and queue its results.
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [6:0]  sx;
    logic        is_pad;
    logic [1:0]  pads;
    logic [23:0] word;
    int          n;
    int          k;
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        clear_quad();
      end
      return;
    end
    live_chars++;
    is_pad = (c == PAD_CHAR);
    sx = is_pad ? 7'd0 : char_sextet(c);
    // Invalid character outranks misplaced padding, which outranks bad length.
    if (sx[6]) begin
      flag_error(ST_BAD_CHAR, last);
      return;
    end
    if (is_pad && quad_pos < 2'd2) begin
      flag_error(ST_BAD_PAD, last);
      return;
    end
    if (!is_pad && pad_count != 2'd0) begin
      flag_error(ST_BAD_PAD, last);
      return;
    end
    if (quad_pos != PHASE_LAST) begin
      if (last) begin
        flag_error(ST_BAD_LEN, 1'b1);
        return;
      end
      if (is_pad) pad_count++;
      sextet_acc = {sextet_acc[11:0], sx[5:0]};
      quad_pos++;
      return;
    end
    // Fourth character: a padded quad must close the message.
    pads = pad_count + {1'b0, is_pad};
    word = {sextet_acc, sx[5:0]};
    if (pads != 2'd0 && !last) begin
      flag_error(ST_BAD_PAD, 1'b0);
      return;
    end
    n = 3 - pads;
    for (k = 0; k < n; k++) begin
      decoded_queue.push_back({word[23 - 8 * k -: 8], last && (k == n - 1), ST_OK});
    end
    clear_quad();
  endtask

  // Drive one character, hold it until the transaction completes, then predict.
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {c, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_char(c, last);
  endtask

  task automatic send_text(input string s, input logic last_on_end);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_char(s[i], last_on_end && (i == s.len() - 1));
    end
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t MISMATCH: %s", $realtime, what);
  endtask

  // Receiver: stall at random, one update per edge.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare every output transaction with the oldest owed result.
  always @(posedge clk) begin : out_check
    b64d_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte=%02h last=%0b status=%0d",
                                  out_data.out_byte, out_data.out_last, out_data.status));
      end else begin
        want = decoded_queue.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    out_data.out_byte, want.out_byte));
        if (out_data.out_last !== want.out_last)
          report_mismatch($sformatf("out_last %0b, want %0b",
                                    out_data.out_last, want.out_last));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    out_data.status, want.status));
      end
    end
  end

  // Full quads spanning both ends of every alphabet range.
  task automatic test_full_quads();
    send_text("AZaz", 1'b0);
    send_text("09+/", 1'b1);
  endtask

  // One and two pad characters, with nonzero leftover bits that must be ignored.
  task automatic test_padding();
    send_text("QUJ=", 1'b1);
    send_text("QR==", 1'b1);
  endtask

  task automatic test_error_cases();
    // Padded quad that does not end the message, then drop up to in_last
    // (the dropped closing character is itself outside the alphabet).
    send_text("QR==", 1'b0);
    send_char(8'hff, 1'b1);
    // Pad in the first position, on the message's last character.
    send_char(PAD_CHAR, 1'b1);
    // Pad in the second position, then one dropped character.
    send_text("A=", 1'b0);
    send_char(8'h00, 1'b1);
    // Data character after a pad.
    send_text("AB=C", 1'b1);
    // Message ends mid-quad.
    send_text("AB", 1'b1);
    // Invalid character wins over misplaced padding on the same character.
    send_text("AB=", 1'b0);
    send_char(8'h80, 1'b1);
  endtask

  // Mostly well-formed messages with random content; some are broken on purpose.
  task automatic send_random_message();
    logic [7:0] msg[$];
    int n_quads;
    int n_pads;
    int mode;
    int i;
    n_quads = $urandom_range(1, 4);
    for (i = 0; i < 4 * n_quads; i++) msg.push_back(sextet_char(6'($urandom_range(0, 63))));
    n_pads = $urandom_range(0, 2);
    for (i = 0; i < n_pads; i++) msg[msg.size() - 1 - i] = PAD_CHAR;
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (mode < 17) begin
      msg[$urandom_range(0, msg.size() - 1)] = PAD_CHAR;
    end else if (mode < 23) begin
      repeat ($urandom_range(1, 3)) if (msg.size() > 1) void'(msg.pop_back());
    end else if (mode < 27) begin
      repeat ($urandom_range(1, 3)) msg.push_back(sextet_char(6'($urandom_range(0, 63))));
    end
    for (i = 0; i < msg.size(); i++) send_char(msg[i], i == msg.size() - 1);
  endtask

  task automatic test_random_messages(input int n_chars);
    int start;
    start = live_chars;
    while (live_chars - start < n_chars) send_random_message();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_full_quads();
    test_padding();
    test_error_cases();
    test_random_messages(35);

    send_idle_pct = 82;
    recv_idle_pct = 21;
    test_random_messages(35);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_messages(35);

    // Drop valid and drain everything still owed.
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_base64_stream_decoder_core: clean");
    end else begin
      $display("tb_base64_stream_decoder_core: errors");
    end
    $finish;
  end

endmodule
